[design/sip_pkg.sv]
package sip_pkg;

    // character codes used by the classifier and the testbench
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_X   = 8'h78;

    // radix codes
    localparam logic [4:0] BASE_AUTO = 5'd0;
    localparam logic [4:0] BASE_ONE  = 5'd1;
    localparam logic [4:0] BASE_OCT  = 5'd8;
    localparam logic [4:0] BASE_DEC  = 5'd10;
    localparam logic [4:0] BASE_HEX  = 5'd16;

    // digit value of a byte that is no digit at all
    localparam logic [4:0] NO_DIGIT  = 5'd16;

    typedef struct packed {
        logic [7:0] character;
        logic       first_of_string;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] parsed_value;
        logic [15:0]        end_offset;
        logic               digits_found;
    } t_out_item;

    // classified byte handed from front to back
    typedef struct packed {
        logic       first;
        logic [4:0] base;
        logic [4:0] digit;
        logic       is_space;
        logic       is_plus;
        logic       is_minus;
        logic       is_zero;
        logic       is_x;
    } t_cls;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_HEXPFX,
        PH_DIGITS,
        PH_DONE
    } t_phase;

endpackage

[design/sip_fifo.sv]
module sip_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // pointer and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= !r_wr_ptr;
            if (do_pop) r_rd_ptr <= !r_rd_ptr;
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

[design/sip_front.sv]
module sip_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [4:0]        i_cfg_wr_data,
    input  logic              i_push,
    input  sip_pkg::t_in_item i_in_item,
    input  logic              i_q_full,
    output logic              o_q_push,
    output sip_pkg::t_cls     o_cls
);

    logic [4:0] r_number_base;
    logic [7:0] ch;

    // radix register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= sip_pkg::BASE_DEC;
        end else if (i_cfg_wr_en) begin
            r_number_base <= i_cfg_wr_data;
        end
    end

    assign ch       = i_in_item.character;
    assign o_q_push = i_push && !i_q_full;

    // byte classification
    always_comb begin
        o_cls.first    = i_in_item.first_of_string;
        o_cls.base     = r_number_base;
        o_cls.is_space = (ch == sip_pkg::CH_SPACE) || (ch == sip_pkg::CH_TAB)
                      || (ch == sip_pkg::CH_LF) || (ch == sip_pkg::CH_VT)
                      || (ch == sip_pkg::CH_FF) || (ch == sip_pkg::CH_CR);
        o_cls.is_plus  = (ch == sip_pkg::CH_PLUS);
        o_cls.is_minus = (ch == sip_pkg::CH_MINUS);
        o_cls.is_zero  = (ch == sip_pkg::CH_ZERO);
        o_cls.is_x     = (ch == sip_pkg::CH_LO_X) || (ch == sip_pkg::CH_UP_X);
        if (ch >= sip_pkg::CH_ZERO && ch <= sip_pkg::CH_NINE) begin
            o_cls.digit = 5'(ch - sip_pkg::CH_ZERO);
        end else if (ch >= sip_pkg::CH_LO_A && ch <= sip_pkg::CH_LO_F) begin
            o_cls.digit = 5'(ch - sip_pkg::CH_LO_A + 8'd10);
        end else if (ch >= sip_pkg::CH_UP_A && ch <= sip_pkg::CH_UP_F) begin
            o_cls.digit = 5'(ch - sip_pkg::CH_UP_A + 8'd10);
        end else begin
            o_cls.digit = sip_pkg::NO_DIGIT;
        end
    end

endmodule

[design/sip_back.sv]
module sip_back #(
    parameter longint unsigned MAX_STRING_LENGTH = 65535,
    parameter int              VALUE_WIDTH       = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sip_pkg::t_cls      i_cls,
    input  logic               i_cls_empty,
    output logic               o_cls_pop,
    input  logic               i_res_full,
    output logic               o_res_push,
    output sip_pkg::t_out_item o_res
);

    localparam int POS_W = $clog2(MAX_STRING_LENGTH + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_STRING_LENGTH);

    sip_pkg::t_phase        r_phase, n_phase, e_phase;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc, e_acc;
    logic                   r_neg, n_neg, e_neg;
    logic [POS_W-1:0]       r_pos, n_pos, e_pos;
    logic [4:0]             r_base, n_base, e_base;
    logic                   r_seen, n_seen, e_seen;
    logic [POS_W-1:0]       r_oaz, n_oaz, e_oaz;

    sip_pkg::t_cls          k;
    logic                   fire;
    logic                   overlong;
    logic                   bad_base;
    logic                   zero_pfx;
    logic [4:0]             t_base;
    logic                   digit_ok;
    logic [VALUE_WIDTH+4:0] mul_full;
    logic [VALUE_WIDTH-1:0] prod;
    logic                   step_emit;
    logic [POS_W-1:0]       off_src;
    logic [VALUE_WIDTH-1:0] mag;
    logic [VALUE_WIDTH-1:0] sval;
    logic [63:0]            off_wide;

    assign fire       = !i_cls_empty && !i_res_full;
    assign o_cls_pop  = fire;
    assign o_res_push = fire && step_emit;

    // state as seen by this byte, after a possible string restart
    assign e_phase = i_cls.first ? sip_pkg::PH_SPACE : r_phase;
    assign e_acc   = i_cls.first ? '0 : r_acc;
    assign e_neg   = i_cls.first ? 1'b0 : r_neg;
    assign e_pos   = i_cls.first ? '0 : r_pos;
    assign e_base  = i_cls.first ? i_cls.base : r_base;
    assign e_seen  = i_cls.first ? 1'b0 : r_seen;
    assign e_oaz   = i_cls.first ? '0 : r_oaz;

    // overlong string reads as end of string
    assign overlong = (e_pos >= MAX_POS);
    always_comb begin
        k = i_cls;
        if (overlong) begin
            k.digit    = sip_pkg::NO_DIGIT;
            k.is_space = 1'b0;
            k.is_plus  = 1'b0;
            k.is_minus = 1'b0;
            k.is_zero  = 1'b0;
            k.is_x     = 1'b0;
        end
    end

    assign bad_base = (e_base == sip_pkg::BASE_ONE) || (e_base > sip_pkg::BASE_HEX);
    assign zero_pfx = k.is_zero
                   && ((e_base == sip_pkg::BASE_AUTO) || (e_base == sip_pkg::BASE_HEX));

    // radix for the digit step, auto detection resolved per phase
    always_comb begin
        case (e_phase)
            sip_pkg::PH_SPACE, sip_pkg::PH_SIGNED:
                t_base = (e_base == sip_pkg::BASE_AUTO) ? sip_pkg::BASE_DEC : e_base;
            sip_pkg::PH_ZERO:
                t_base = (e_base == sip_pkg::BASE_AUTO) ? sip_pkg::BASE_OCT : e_base;
            default:
                t_base = e_base;
        endcase
    end

    // digit accumulate
    assign digit_ok = (k.digit < t_base);
    assign mul_full = e_acc * t_base;
    assign prod     = mul_full[VALUE_WIDTH-1:0] + VALUE_WIDTH'(k.digit);

    // next phase
    always_comb begin
        case (e_phase)
            sip_pkg::PH_SPACE: begin
                if (bad_base) n_phase = sip_pkg::PH_DONE;
                else if (k.is_space) n_phase = sip_pkg::PH_SPACE;
                else if (k.is_plus || k.is_minus) n_phase = sip_pkg::PH_SIGNED;
                else if (zero_pfx) n_phase = sip_pkg::PH_ZERO;
                else if (digit_ok) n_phase = sip_pkg::PH_DIGITS;
                else n_phase = sip_pkg::PH_DONE;
            end
            sip_pkg::PH_SIGNED: begin
                if (zero_pfx) n_phase = sip_pkg::PH_ZERO;
                else if (digit_ok) n_phase = sip_pkg::PH_DIGITS;
                else n_phase = sip_pkg::PH_DONE;
            end
            sip_pkg::PH_ZERO: begin
                if (k.is_x) n_phase = sip_pkg::PH_HEXPFX;
                else if (digit_ok) n_phase = sip_pkg::PH_DIGITS;
                else n_phase = sip_pkg::PH_DONE;
            end
            sip_pkg::PH_HEXPFX, sip_pkg::PH_DIGITS: begin
                n_phase = digit_ok ? sip_pkg::PH_DIGITS : sip_pkg::PH_DONE;
            end
            default: n_phase = sip_pkg::PH_DONE;
        endcase
    end

    // datapath updates and result emission
    always_comb begin
        n_acc     = e_acc;
        n_neg     = e_neg;
        n_base    = e_base;
        n_seen    = e_seen;
        n_oaz     = e_oaz;
        step_emit = 1'b0;
        off_src   = e_pos;
        n_pos     = (e_phase == sip_pkg::PH_DONE || overlong) ? e_pos : e_pos + 1'b1;
        case (e_phase)
            sip_pkg::PH_SPACE, sip_pkg::PH_SIGNED: begin
                if (e_phase == sip_pkg::PH_SPACE && bad_base) begin
                    step_emit = 1'b1;
                end else if (e_phase == sip_pkg::PH_SPACE && k.is_space) begin
                    n_acc = e_acc;
                end else if (e_phase == sip_pkg::PH_SPACE && (k.is_plus || k.is_minus)) begin
                    n_neg = k.is_minus;
                end else if (zero_pfx) begin
                    n_seen = 1'b1;
                    n_acc  = '0;
                    n_oaz  = e_pos + 1'b1;
                end else begin
                    n_base = t_base;
                    if (digit_ok) begin
                        n_acc  = prod;
                        n_seen = 1'b1;
                    end else begin
                        step_emit = 1'b1;
                    end
                end
            end
            sip_pkg::PH_ZERO: begin
                if (k.is_x) begin
                    n_base = sip_pkg::BASE_HEX;
                end else begin
                    n_base = t_base;
                    if (digit_ok) begin
                        n_acc  = prod;
                        n_seen = 1'b1;
                    end else begin
                        step_emit = 1'b1;
                    end
                end
            end
            sip_pkg::PH_HEXPFX, sip_pkg::PH_DIGITS: begin
                if (digit_ok) begin
                    n_acc  = prod;
                    n_seen = 1'b1;
                end else begin
                    step_emit = 1'b1;
                    if (e_phase == sip_pkg::PH_HEXPFX) off_src = e_oaz;
                end
            end
            default: begin
                step_emit = 1'b0;
            end
        endcase
    end

    // result formatting
    assign mag      = e_neg ? (VALUE_WIDTH'(0) - e_acc) : e_acc;
    assign sval     = e_seen ? mag : '0;
    assign off_wide = 64'(off_src);
    assign o_res.parsed_value = 64'(signed'(sval));
    assign o_res.end_offset   = e_seen ? off_wide[15:0] : 16'd0;
    assign o_res.digits_found = e_seen;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sip_pkg::PH_SPACE;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_pos   <= '0;
            r_base  <= sip_pkg::BASE_DEC;
            r_seen  <= 1'b0;
            r_oaz   <= '0;
        end else if (fire) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_pos   <= n_pos;
            r_base  <= n_base;
            r_seen  <= n_seen;
            r_oaz   <= n_oaz;
        end
    end

    // a result always closes the string
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && step_emit |=> r_phase == sip_pkg::PH_DONE)
        else $error("phase not done after result");

    // a closed string stays silent until restarted
    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !i_cls.first && r_phase == sip_pkg::PH_DONE |-> !step_emit)
        else $error("result from a finished string");

    // position saturates at the length limit
    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= MAX_POS)
        else $error("position beyond limit");

    // no digit means zero value and zero offset
    a_no_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push && !o_res.digits_found |->
            o_res.parsed_value == 64'sd0 && o_res.end_offset == 16'd0)
        else $error("nonzero result without digits");

endmodule

[design/string_to_integer_parser_top.sv]
// string to integer parser, strtol style, one byte per transaction
// input channel: drive i_in_item and raise push; the byte is taken at a
//   clock edge where push is high and full is low
// result channel: while empty is low, o_out_item holds the oldest result;
//   raise pop to take it
// configuration: i_cfg_wr_en writes i_cfg_wr_data into the radix register
//   (0 auto, 2..16); it is sampled when a byte flagged first_of_string arrives
// throughput: one byte per cycle sustained while results are popped; the back end does one
//   parse step per cycle when not stalled, a 64 by 5 bit multiply-add per digit
// path: the byte that ends the number waits in the byte queue, the parse step
//   writes its result into the result queue, and pop then takes it from there
// each string gives at most one result; later bytes are dropped until the
//   next first_of_string
// reset: queues empty, radix 10, parser as if a radix 10 string just began
// stall: when pop stays low the two entry result queue fills, the parser
//   halts, the two entry byte queue fills and full rises; nothing is lost
module string_to_integer_parser_top #(
    parameter longint unsigned MAX_STRING_LENGTH = 65535,
    parameter int              VALUE_WIDTH       = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [4:0]         i_cfg_wr_data,
    input  logic               push,
    output logic               full,
    input  sip_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  logic               pop,
    output sip_pkg::t_out_item o_out_item
);

    localparam int CLS_W = $bits(sip_pkg::t_cls);
    localparam int RES_W = $bits(sip_pkg::t_out_item);

    sip_pkg::t_cls      front_cls;
    logic               front_push;
    logic [CLS_W-1:0]   q_data;
    logic               q_empty;
    logic               q_pop;
    sip_pkg::t_out_item back_res;
    logic               back_push;
    logic               res_full;
    logic [RES_W-1:0]   res_data;

    // classifier and radix register
    sip_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_push        (push),
        .i_in_item     (i_in_item),
        .i_q_full      (full),
        .o_q_push      (front_push),
        .o_cls         (front_cls)
    );

    // classified byte queue
    sip_fifo #(.WIDTH(CLS_W)) u_byte_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cls),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    // parse sequencer
    sip_back #(
        .MAX_STRING_LENGTH (MAX_STRING_LENGTH),
        .VALUE_WIDTH       (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls       (sip_pkg::t_cls'(q_data)),
        .i_cls_empty (q_empty),
        .o_cls_pop   (q_pop),
        .i_res_full  (res_full),
        .o_res_push  (back_push),
        .o_res       (back_res)
    );

    // result queue
    sip_fifo #(.WIDTH(RES_W)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_data),
        .o_empty (empty)
    );

    assign o_out_item = sip_pkg::t_out_item'(res_data);

endmodule

[test/string_to_integer_parser_top_tb.sv]
module string_to_integer_parser_top_tb;

    localparam int unsigned MAX_LEN     = 65535;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASE_ITEMS = 150;
    localparam int unsigned TAIL_ITEMS  = 60;
    localparam logic [7:0]  BLANKS [6]  = '{sip_pkg::CH_SPACE, sip_pkg::CH_TAB,
                                           sip_pkg::CH_LF, sip_pkg::CH_VT,
                                           sip_pkg::CH_FF, sip_pkg::CH_CR};

    // strtol style predictor with the queue of results it expects
    class conversion_board;
        logic [4:0]         radix_cfg;
        sip_pkg::t_phase    phase;
        logic [63:0]        acc;
        bit                 negative;
        int unsigned        position;
        logic [4:0]         radix_active;
        bit                 have_digit;
        int unsigned        zero_end;
        sip_pkg::t_out_item expected_q[$];
        int unsigned        errors;

        function new();
            errors    = 0;
            radix_cfg = sip_pkg::BASE_DEC;
            open_string();
        endfunction

        function void set_radix(logic [4:0] radix);
            radix_cfg = radix;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void open_string();
            phase        = sip_pkg::PH_SPACE;
            acc          = '0;
            negative     = 1'b0;
            position     = 0;
            radix_active = radix_cfg;
            have_digit   = 1'b0;
            zero_end     = 0;
        endfunction

        function logic [4:0] digit_value(logic [7:0] ch);
            if (ch >= sip_pkg::CH_ZERO && ch <= sip_pkg::CH_NINE)
                return 5'(ch - sip_pkg::CH_ZERO);
            if (ch >= sip_pkg::CH_LO_A && ch <= sip_pkg::CH_LO_F)
                return 5'(ch - sip_pkg::CH_LO_A + 8'd10);
            if (ch >= sip_pkg::CH_UP_A && ch <= sip_pkg::CH_UP_F)
                return 5'(ch - sip_pkg::CH_UP_A + 8'd10);
            return sip_pkg::NO_DIGIT;
        endfunction

        // conversion ends here, one result goes out
        function void close_number(int unsigned offset);
            sip_pkg::t_out_item res;
            res = '0;
            if (have_digit) begin
                res.parsed_value = negative ? -acc : acc;
                res.end_offset   = offset[15:0];
                res.digits_found = 1'b1;
            end
            expected_q.push_back(res);
            phase = sip_pkg::PH_DONE;
        endfunction

        function void add_digit(logic [7:0] ch, int unsigned pos);
            logic [4:0] d;
            d = digit_value(ch);
            if (d < radix_active) begin
                acc        = acc * 64'(radix_active) + 64'(d);
                have_digit = 1'b1;
                phase      = sip_pkg::PH_DIGITS;
            end else begin
                close_number(pos);
            end
        endfunction

        // one accepted input transaction; ignored bytes change nothing
        function void take_byte(sip_pkg::t_in_item it);
            logic [7:0]  ch;
            int unsigned pos;
            ch = it.character;
            if (it.first_of_string) open_string();
            if (phase == sip_pkg::PH_DONE) return;
            pos = position;
            if (pos >= MAX_LEN) ch = sip_pkg::CH_NUL;
            else position = pos + 1;

            // leading blanks and sign, otherwise fall into the first digit
            if (phase == sip_pkg::PH_SPACE) begin
                if (radix_active == sip_pkg::BASE_ONE || radix_active > sip_pkg::BASE_HEX) begin
                    close_number(0);
                    return;
                end
                if ((ch >= sip_pkg::CH_TAB && ch <= sip_pkg::CH_CR) || ch == sip_pkg::CH_SPACE)
                    return;
                if (ch == sip_pkg::CH_PLUS || ch == sip_pkg::CH_MINUS) begin
                    negative = (ch == sip_pkg::CH_MINUS);
                    phase    = sip_pkg::PH_SIGNED;
                    return;
                end
                phase = sip_pkg::PH_SIGNED;
            end

            case (phase)
                sip_pkg::PH_SIGNED: begin
                    if (ch == sip_pkg::CH_ZERO && (radix_active == sip_pkg::BASE_AUTO
                                                || radix_active == sip_pkg::BASE_HEX)) begin
                        have_digit = 1'b1;
                        acc        = '0;
                        zero_end   = pos + 1;
                        phase      = sip_pkg::PH_ZERO;
                    end else begin
                        if (radix_active == sip_pkg::BASE_AUTO) radix_active = sip_pkg::BASE_DEC;
                        add_digit(ch, pos);
                    end
                end
                sip_pkg::PH_ZERO: begin
                    if (ch == sip_pkg::CH_LO_X || ch == sip_pkg::CH_UP_X) begin
                        radix_active = sip_pkg::BASE_HEX;
                        phase        = sip_pkg::PH_HEXPFX;
                    end else begin
                        if (radix_active == sip_pkg::BASE_AUTO) radix_active = sip_pkg::BASE_OCT;
                        add_digit(ch, pos);
                    end
                end
                sip_pkg::PH_HEXPFX: begin
                    // bare prefix ends just after the zero
                    if (digit_value(ch) < sip_pkg::NO_DIGIT) add_digit(ch, pos);
                    else close_number(zero_end);
                end
                sip_pkg::PH_DIGITS: add_digit(ch, pos);
                default: phase = sip_pkg::PH_DONE;
            endcase
        endfunction

        // one accepted result transaction against the oldest expectation
        function void check_result(sip_pkg::t_out_item got);
            sip_pkg::t_out_item want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: parsed_value %0d end_offset %0d digits_found %0d",
                       got.parsed_value, got.end_offset, got.digits_found);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.parsed_value !== want.parsed_value) begin
                $error("parsed_value expected %0d actual %0d",
                       want.parsed_value, got.parsed_value);
                errors++;
            end
            if (got.end_offset !== want.end_offset) begin
                $error("end_offset expected %0d actual %0d", want.end_offset, got.end_offset);
                errors++;
            end
            if (got.digits_found !== want.digits_found) begin
                $error("digits_found expected %0d actual %0d",
                       want.digits_found, got.digits_found);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic [4:0]         i_cfg_wr_data = sip_pkg::BASE_DEC;
    logic               push          = 1'b0;
    logic               full;
    sip_pkg::t_in_item  i_in_item     = '0;
    logic               empty;
    logic               pop           = 1'b0;
    sip_pkg::t_out_item o_out_item;

    conversion_board board = new();
    logic [4:0]  radix_now     = sip_pkg::BASE_DEC;
    int unsigned bytes_taken   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned cycles        = 0;

    string_to_integer_parser_top #(
        .MAX_STRING_LENGTH(MAX_LEN),
        .VALUE_WIDTH      (64)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .push         (push),
        .full         (full),
        .i_in_item    (i_in_item),
        .empty        (empty),
        .pop          (pop),
        .o_out_item   (o_out_item)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("string_to_integer_parser_top_tb: FAIL");
            $finish;
        end
    end

    // result side: check accepted transactions, stall in random bursts
    initial begin : result_side
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) board.check_result(o_out_item);
            if (stall > 0) begin
                stall--;
                pop <= 1'b0;
            end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
                stall = $urandom_range(0, 7);
                pop   <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // one input transaction, with an optional idle burst ahead of it
    task automatic send_byte(logic [7:0] ch, bit first);
        sip_pkg::t_in_item it;
        it.character       = ch;
        it.first_of_string = first;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        board.take_byte(it);
        bytes_taken++;
    endtask

    task automatic send_text(string s, bit first);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], first && i == 0);
    endtask

    // radix write once the parser has drained
    task automatic write_radix(logic [4:0] radix);
        push <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= radix;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        board.set_radix(radix);
        radix_now = radix;
    endtask

    // mostly well formed numbers with random content, some noise
    task automatic send_random_string();
        logic [7:0] text[$];
        int         eff, n, pick, v;
        bit         x_prefix, zero_prefix, flagged;
        flagged = ($urandom_range(0, 15) != 0);
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) text.push_back(BLANKS[$urandom_range(0, 5)]);
            pick = $urandom_range(0, 2);
            if (pick == 1) text.push_back(sip_pkg::CH_PLUS);
            if (pick == 2) text.push_back(sip_pkg::CH_MINUS);
            pick        = $urandom_range(0, 5);
            zero_prefix = (pick <= 2);
            x_prefix    = (pick == 1 || pick == 2);
            if (zero_prefix) text.push_back(sip_pkg::CH_ZERO);
            if (pick == 1) text.push_back(sip_pkg::CH_LO_X);
            if (pick == 2) text.push_back(sip_pkg::CH_UP_X);
            if (radix_now == sip_pkg::BASE_AUTO) eff = x_prefix ? 16 : (zero_prefix ? 8 : 10);
            else if (radix_now == sip_pkg::BASE_ONE || radix_now > sip_pkg::BASE_HEX) eff = 16;
            else eff = x_prefix ? 16 : int'(radix_now);
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
            repeat (n) begin
                v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(0, eff - 1);
                if (v < 10) text.push_back(sip_pkg::CH_ZERO + 8'(v));
                else text.push_back(($urandom_range(0, 1) ? sip_pkg::CH_LO_A : sip_pkg::CH_UP_A)
                                    + 8'(v - 10));
            end
            // terminator; none leaves the string open for the next one
            case ($urandom_range(0, 3))
                0: text.push_back(sip_pkg::CH_NUL);
                1: text.push_back(8'($urandom_range(0, 255)));
                2: text.push_back(sip_pkg::CH_SPACE);
                default: ;
            endcase
            repeat ($urandom_range(0, 2)) text.push_back(8'($urandom_range(0, 255)));
        end
        foreach (text[i]) send_byte(text[i], flagged && i == 0);
    endtask

    // stimulus
    initial begin : stimulus
        logic [4:0] radix_plan [10];
        radix_plan = '{sip_pkg::BASE_DEC, sip_pkg::BASE_AUTO, sip_pkg::BASE_HEX, 5'd2,
                       sip_pkg::BASE_OCT, sip_pkg::BASE_ONE, 5'd31, 5'd17,
                       5'($urandom_range(0, 31)), 5'($urandom_range(0, 16))};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unflagged start continues the string opened by reset, radix 10
        send_text("-12", 1'b0);
        send_byte(sip_pkg::CH_NUL, 1'b0);
        // ignored after the result
        send_byte(sip_pkg::CH_LO_X, 1'b0);
        send_text("\t+9", 1'b1);
        send_byte(8'hFF, 1'b0);

        // automatic radix: bare hex prefix, octal with sign, then a hex number
        write_radix(sip_pkg::BASE_AUTO);
        send_text("0Xz", 1'b1);
        send_text("-07", 1'b1);
        send_byte(8'h80, 1'b0);
        send_text("0x1F", 1'b1);
        send_byte(sip_pkg::CH_NUL, 1'b0);

        // invalid radix ends at the first byte, then binary stopped by a bad digit
        write_radix(sip_pkg::BASE_ONE);
        send_text("5", 1'b1);
        write_radix(5'd31);
        send_text(" ", 1'b1);
        write_radix(5'd2);
        send_text("102", 1'b1);

        // random phases over several radix settings
        foreach (radix_plan[p]) begin
            write_radix(radix_plan[p]);
            case ($urandom_range(0, 2))
                0: send_idle_pct = 0;
                1: send_idle_pct = 8;
                default: send_idle_pct = 35;
            endcase
            case ($urandom_range(0, 2))
                0: recv_idle_pct = 0;
                1: recv_idle_pct = 8;
                default: recv_idle_pct = 35;
            endcase
            bytes_taken = 0;
            while (bytes_taken < PHASE_ITEMS) send_random_string();
        end

        // last part without idling, radix 10
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_radix(sip_pkg::BASE_DEC);
        bytes_taken = 0;
        while (bytes_taken < TAIL_ITEMS) send_random_string();

        push <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("string_to_integer_parser_top_tb: PASS");
        end else begin
            $display("string_to_integer_parser_top_tb: FAIL");
        end
        $finish;
    end

endmodule
